// ----- design/tkpc_pkg.sv -----
// Shared types, constants and helpers of the touch key press classifier.
package tkpc_pkg;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned CODES_W = 3 * KEY_W;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned NKEYS   = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W   = CODES_W;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODES_LEFT    = 3'd0,
    CFG_CODES_RIGHT   = 3'd1,
    CFG_LONG_SCANS    = 3'd2,
    CFG_HOLD_INTERVAL = 3'd3,
    CFG_RELEASE_SCANS = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HOLD = 2'd1,
    PH_WAIT = 2'd2
  } phase_t;

  // Result of looking a code up in the six configured key codes.
  typedef struct packed {
    logic found;
    idx_t idx;
  } match_t;

  localparam cnt_t CNT_MAX         = '1;
  localparam cnt_t LONG_SCANS_RST  = 16'd100;
  localparam cnt_t HOLD_INTV_RST   = 16'd100;
  localparam cnt_t RELEASE_RST     = 16'd20;

  // Increment that sticks at the counter's largest value.
  function automatic cnt_t sat_inc(input cnt_t v);
    cnt_t r;
    r = (v == CNT_MAX) ? CNT_MAX : v + cnt_t'(1);
    return r;
  endfunction

endpackage

// ----- design/tkpc_in_if.sv -----
// Scan input channel: one key code per beat.
interface tkpc_in_if;
  import tkpc_pkg::*;

  logic valid;
  logic ready;
  key_t key_code;

  modport source (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

// ----- design/tkpc_out_if.sv -----
// Result channel: press events and the key they belong to, one result per beat.
interface tkpc_out_if;
  import tkpc_pkg::*;

  logic valid;
  logic ready;
  logic short_press;
  logic long_press;
  logic repeat_press;
  idx_t key_index;

  modport source (output valid, output short_press, output long_press,
                  output repeat_press, output key_index, input ready);
  modport sink (input valid, input short_press, input long_press,
                input repeat_press, input key_index, output ready);
endinterface

// ----- design/tkpc_key_match.sv -----
// Priority lookup of a code among the three left and three right key codes.
module tkpc_key_match (
  input  logic [tkpc_pkg::CODES_W-1:0] codes_left,
  input  logic [tkpc_pkg::CODES_W-1:0] codes_right,
  input  tkpc_pkg::key_t               code,
  output tkpc_pkg::match_t             match
);
  import tkpc_pkg::*;

  key_t keys [NKEYS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      keys[i]     = codes_left[i*KEY_W +: KEY_W];
      keys[i + 3] = codes_right[i*KEY_W +: KEY_W];
    end
  end

  // Scan from the top so that the lowest matching index is the one kept.
  always_comb begin
    match = '0;
    for (int i = NKEYS - 1; i >= 0; i--) begin
      if (keys[i] == code) begin
        match.found = 1'b1;
        match.idx   = idx_t'(i);
      end
    end
  end

endmodule

// ----- design/touch_key_press_classifier_unit.sv -----
// Top level of the touch key press classifier: scan register, press state and result register.
//
// Each beat on in_chan carries one touch-scan key code and produces exactly one result beat on
// out_chan, in order, flagging a short press, a long press and/or a hold repeat together with
// the key index (0-2 left keys, 3-5 right keys; zero when no event). The block takes one scan
// per clock cycle unless out_chan stalls: a beat is captured in a scan register, classified
// by the compare and saturating-counter logic and lands in the result register; a full result
// register that is being read does not stop the next beat from being taken. A short press of
// a code not in the table gives no event but still waits for release; a long hold of an
// unknown code gives no events. The user writes configuration through the cfg_ port only while
// no beat is in flight; the block does not enforce it. Writes to indexes above 4 are dropped.
module touch_key_press_classifier_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  tkpc_in_if.sink                         in_chan,
  tkpc_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [tkpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tkpc_pkg::CFG_W-1:0]      cfg_wdata
);
  import tkpc_pkg::*;

  // Configuration registers.
  logic [CODES_W-1:0] codes_left_r;
  logic [CODES_W-1:0] codes_right_r;
  cnt_t               long_scans_r;
  cnt_t               hold_interval_r;
  cnt_t               release_scans_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_left_r    <= '0;
      codes_right_r   <= '0;
      long_scans_r    <= LONG_SCANS_RST;
      hold_interval_r <= HOLD_INTV_RST;
      release_scans_r <= RELEASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CODES_LEFT:    codes_left_r    <= cfg_wdata[CODES_W-1:0];
        CFG_CODES_RIGHT:   codes_right_r   <= cfg_wdata[CODES_W-1:0];
        CFG_LONG_SCANS:    long_scans_r    <= cfg_wdata[CNT_W-1:0];
        CFG_HOLD_INTERVAL: hold_interval_r <= cfg_wdata[CNT_W-1:0];
        CFG_RELEASE_SCANS: release_scans_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Scan register and handshake. The scan moves on whenever the result register is empty or
  // is being emptied in this cycle.
  logic s1_valid_r;
  key_t s1_key_r;
  logic s1_fire;
  logic out_valid_r;

  assign s1_fire      = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_key_r <= in_chan.key_code;
    end
  end

  // Press state.
  phase_t phase_r, phase_nxt;
  key_t   held_code_r, held_code_nxt;
  cnt_t   press_count_r, press_count_nxt;
  cnt_t   release_count_r, release_count_nxt;

  // Every event concerns the held code: a short press reports it, and long and repeat
  // events only fire while the scan equals it.
  match_t held_match;

  tkpc_key_match u_match (
    .codes_left  (codes_left_r),
    .codes_right (codes_right_r),
    .code        (held_code_r),
    .match       (held_match)
  );

  logic is_idle;
  logic held_zero;
  logic same;
  cnt_t idle_pc_inc;
  logic go_long;
  logic go_short;
  logic in_hold;
  cnt_t hold_pc_inc;
  logic rep_hit;
  logic in_wait;
  cnt_t rel_inc;
  logic rel_done;

  // Decisions shared by the next-state and event logic.
  always_comb begin
    is_idle     = (phase_r != PH_HOLD) && (phase_r != PH_WAIT);
    held_zero   = (held_code_r == '0);
    same        = (held_code_r == s1_key_r);
    idle_pc_inc = sat_inc(press_count_r);
    go_long     = is_idle && !held_zero && same && (idle_pc_inc >= long_scans_r);
    go_short    = is_idle && !held_zero && !same;
    // A long press enters hold in the same scan, with the count restarted from zero.
    in_hold     = (phase_r == PH_HOLD) || go_long;
    hold_pc_inc = go_long ? cnt_t'(1) : sat_inc(press_count_r);
    rep_hit     = in_hold && same && held_match.found && (hold_pc_inc >= hold_interval_r);
    // The scan that ends a press already counts toward release.
    in_wait     = (phase_r == PH_WAIT) || go_short || (in_hold && !same);
    rel_inc     = (s1_key_r == '0) ? sat_inc(release_count_r) : '0;
    rel_done    = rel_inc >= release_scans_r;
  end

  // Next state.
  always_comb begin
    phase_nxt         = phase_r;
    held_code_nxt     = held_code_r;
    press_count_nxt   = press_count_r;
    release_count_nxt = release_count_r;

    if (is_idle) begin
      phase_nxt = PH_IDLE;
      if (held_zero) begin
        held_code_nxt = s1_key_r;
      end else if (same) begin
        press_count_nxt = go_long ? '0 : idle_pc_inc;
      end
    end

    if (in_hold) begin
      if (same) begin
        phase_nxt       = PH_HOLD;
        press_count_nxt = rep_hit ? '0 : hold_pc_inc;
      end
    end

    if (in_wait) begin
      phase_nxt         = PH_WAIT;
      release_count_nxt = rel_done ? '0 : rel_inc;
      if (rel_done) begin
        held_code_nxt   = '0;
        press_count_nxt = '0;
        phase_nxt       = PH_IDLE;
      end
    end
  end

  // Events of this scan.
  logic ev_short, ev_long, ev_rep;
  idx_t ev_idx;

  always_comb begin
    ev_short = go_short && held_match.found;
    ev_long  = go_long && held_match.found;
    ev_rep   = rep_hit;
    ev_idx   = (ev_short || ev_long || ev_rep) ? held_match.idx : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      held_code_r     <= '0;
      press_count_r   <= '0;
      release_count_r <= '0;
    end else if (s1_fire) begin
      phase_r         <= phase_nxt;
      held_code_r     <= held_code_nxt;
      press_count_r   <= press_count_nxt;
      release_count_r <= release_count_nxt;
    end
  end

  // Result register.
  logic out_short_r, out_long_r, out_rep_r;
  idx_t out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_short_r <= ev_short;
      out_long_r  <= ev_long;
      out_rep_r   <= ev_rep;
      out_idx_r   <= ev_idx;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.short_press  = out_short_r;
  assign out_chan.long_press   = out_long_r;
  assign out_chan.repeat_press = out_rep_r;
  assign out_chan.key_index    = out_idx_r;

  // A cleared held code means no press is in progress and the press count is at rest.
  a_held_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (held_code_r == '0) |-> (phase_r == PH_IDLE && press_count_r == '0))
    else $error("held code cleared while a press is in progress");

  // A short press ends the press, so it never comes with a long or repeat event.
  a_short_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_short_r) |-> (!out_long_r && !out_rep_r))
    else $error("short press reported together with a long or repeat event");

  // Reported key indexes stay within the six keys.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_idx_r <= idx_t'(NKEYS - 1)))
    else $error("key index out of range");

  // The scan register only loses its beat by passing it to the result register.
  a_scan_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_chan.ready) |=> s1_valid_r)
    else $error("scan dropped while result register was stalled");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench of the touch key press classifier: directed and random scan traffic.
module tb_top;
  import tkpc_pkg::*;

  // Register indexes past the last register; writes to them must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  // Upper bound on the simulated time of the whole run.
  localparam int unsigned RUN_LIMIT = 4_000_000;

  // Size of each random phase, in scans.
  localparam int unsigned PHASE_SCANS = 220;

  // One result beat as the checker sees it.
  typedef struct packed {
    logic short_ev;
    logic long_ev;
    logic rep_ev;
    idx_t key_idx;
  } press_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  tkpc_in_if in_chan ();
  tkpc_out_if out_chan ();

  touch_key_press_classifier_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Handshake pressure. The sender idles and the receiver stalls with these odds, in percent,
  // drawn fresh on every cycle so that gaps land on every step of a press sequence.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Predicted press events, oldest first, one per accepted scan beat.
  press_result_t pending_events[$];

  int unsigned scans_sent;
  int unsigned results_seen;
  int unsigned short_seen;
  int unsigned long_seen;
  int unsigned repeat_seen;
  int unsigned error_count;

  // Shadow of the key table and the thresholds, updated on every register write.
  logic [CODES_W-1:0] tbl_left;
  logic [CODES_W-1:0] tbl_right;
  cnt_t long_thr;
  cnt_t hold_thr;
  cnt_t rel_thr;

  // Shadow of the press state machine.
  phase_t ph;
  key_t held;
  cnt_t press_cnt;
  cnt_t rel_cnt;

  function automatic cnt_t bump(input cnt_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Scans left keys one to three, then right keys one to three; the first equal code wins.
  function automatic match_t lookup_code(input key_t code);
    logic [2*CODES_W-1:0] all_codes;
    match_t m;
    all_codes = {tbl_right, tbl_left};
    m = '0;
    for (int i = 0; i < NKEYS; i++) begin
      if (!m.found && all_codes[KEY_W*i +: KEY_W] == code) begin
        m.found = 1'b1;
        m.idx = idx_t'(i);
      end
    end
    return m;
  endfunction

  // Advances the shadow state by one scan and returns the event that scan must produce.
  function automatic press_result_t classify_scan(input key_t code);
    press_result_t r;
    match_t m;
    logic go_short;
    logic go_long;
    r = '0;
    go_short = 1'b0;
    go_long = 1'b0;

    // Idle: latch the first nonzero code, then count equal scans toward a long press.
    // A different code before that is a short press of the latched code.
    if (ph != PH_HOLD && ph != PH_WAIT) begin
      ph = PH_IDLE;
      if (held == '0) begin
        held = code;
      end else if (held == code) begin
        press_cnt = bump(press_cnt);
        if (press_cnt >= long_thr) begin
          press_cnt = '0;
          go_long = 1'b1;
        end
      end else begin
        go_short = 1'b1;
      end
    end

    // An unknown code still moves the state machine on, it just reports nothing.
    if (go_short) begin
      m = lookup_code(held);
      if (m.found) begin
        r.short_ev = 1'b1;
        r.key_idx = m.idx;
      end
      ph = PH_WAIT;
    end
    if (go_long) begin
      m = lookup_code(code);
      if (m.found) begin
        r.long_ev = 1'b1;
        r.key_idx = m.idx;
      end
      ph = PH_HOLD;
    end

    // Hold runs in the same scan as the long press, so a hold interval of one gives
    // the long press and the first repeat together. An unknown code never resets the
    // count, which then sticks at its top value.
    if (ph == PH_HOLD) begin
      if (held == code) begin
        press_cnt = bump(press_cnt);
        m = lookup_code(code);
        if (m.found && press_cnt >= hold_thr) begin
          press_cnt = '0;
          r.rep_ev = 1'b1;
          r.key_idx = m.idx;
        end
      end else begin
        ph = PH_WAIT;
      end
    end

    // Release: the scan that entered this phase already counts, and any touch restarts it.
    if (ph == PH_WAIT) begin
      rel_cnt = (code == '0) ? bump(rel_cnt) : '0;
      if (rel_cnt >= rel_thr) begin
        rel_cnt = '0;
        held = '0;
        press_cnt = '0;
        ph = PH_IDLE;
      end
    end
    return r;
  endfunction

  // Register writes go to the shadow copy at the same edge the block takes them.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    case (index)
      CFG_CODES_LEFT:    tbl_left = value;
      CFG_CODES_RIGHT:   tbl_right = value;
      CFG_LONG_SCANS:    long_thr = value[CNT_W-1:0];
      CFG_HOLD_INTERVAL: hold_thr = value[CNT_W-1:0];
      CFG_RELEASE_SCANS: rel_thr = value[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_codes(input logic [CODES_W-1:0] left, input logic [CODES_W-1:0] right);
    write_reg(CFG_CODES_LEFT, left);
    write_reg(CFG_CODES_RIGHT, right);
  endtask

  // Threshold writes carry random upper bits, which the block must drop.
  task automatic set_thresholds(input cnt_t long_n, input cnt_t hold_n, input cnt_t rel_n);
    write_reg(CFG_LONG_SCANS, {$urandom(), long_n});
    write_reg(CFG_HOLD_INTERVAL, {$urandom(), hold_n});
    write_reg(CFG_RELEASE_SCANS, {$urandom(), rel_n});
  endtask

  // Sends one scan beat. The expected event is predicted at the edge that accepts the beat.
  // Valid stays high after the beat so that back-to-back beats need no second assignment.
  task automatic send_scan(input key_t code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.key_code = code;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    pending_events.push_back(classify_scan(code));
    scans_sent++;
    @(negedge clk);
  endtask

  task automatic send_run(input key_t code, input int unsigned count);
    repeat (count) send_scan(code);
  endtask

  // The block is idle once every predicted event has come out.
  task automatic wait_results_done();
    in_chan.valid = 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
  endtask

  // Straight after reset the table is all zero, so every touched code is unknown,
  // and the release needs the default twenty zero scans.
  task automatic test_reset_defaults();
    send_scan(16'h1234);
    send_run(16'h1234, 2);
    send_scan(16'h4321);
    send_run(16'h0000, 21);
    wait_results_done();
  endtask

  // Every key gets a short press; then a long press with a repeat, and an unknown code
  // both as a short press and held long. The codes take the all-ones and single-bit extremes.
  task automatic test_press_kinds();
    key_t keys[NKEYS];
    keys = '{16'hFFFF, 16'h8000, 16'h0001, 16'h5A5A, 16'h0F00, 16'h00F0};
    set_codes({keys[2], keys[1], keys[0]}, {keys[5], keys[4], keys[3]});
    set_thresholds(16'd3, 16'd2, 16'd1);
    for (int i = 0; i < NKEYS; i++) begin
      send_scan(keys[i]);
      send_scan(16'h0000);
    end
    send_run(keys[0], 5);
    send_scan(16'h0000);
    send_scan(16'h7FFE);
    send_scan(keys[1]);
    send_scan(16'h0000);
    send_run(16'h7FFE, 5);
    send_scan(16'h0000);
    wait_results_done();
  endtask

  // Zero thresholds are met at once, duplicate codes report the first slot, a release
  // is broken by a touch, and a hold interval of one merges long press and repeat.
  // Writes past the last register index are mixed in and must change nothing.
  task automatic test_thresholds_and_table();
    set_codes({16'hA5A5, 16'h1357, 16'h2468}, {16'h0F0F, 16'h1357, 16'hC3C3});
    set_thresholds(16'd0, 16'd0, 16'd0);
    for (int i = CFG_IDX_SPARE_LO; i <= CFG_IDX_SPARE_HI; i++) begin
      write_reg(i[CFG_IDX_W-1:0], CFG_W'({$urandom(), $urandom()}));
    end
    send_run(16'h1357, 3);
    send_scan(16'h0000);
    send_run(16'h0F0F, 2);
    send_scan(16'h2468);
    send_scan(16'h0000);
    wait_results_done();
    set_thresholds(16'd2, 16'd1, 16'd2);
    send_run(16'hC3C3, 5);
    send_scan(16'h0000);
    send_scan(16'hC3C3);
    send_run(16'h0000, 2);
    wait_results_done();
  endtask

  // Long counts at full rate: an unknown code held well past the hold interval keeps
  // counting with no repeat, then made known so the grown count fires a repeat at once;
  // a long release; and a long press with a hold interval of one.
  task automatic test_counter_limits();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_codes({16'h0003, 16'h0002, 16'h0001}, {16'h0006, 16'h0005, 16'h0004});
    set_thresholds(16'd1, 16'd40, 16'd40);
    send_run(16'hBEEF, 48);
    wait_results_done();
    write_reg(CFG_CODES_RIGHT, {16'hBEEF, 16'h0005, 16'h0004});
    send_scan(16'hBEEF);
    send_run(16'h0000, 40);
    wait_results_done();
    set_thresholds(16'd60, 16'd1, 16'd1);
    send_run(16'h0001, 62);
    send_scan(16'h0000);
    wait_results_done();
  endtask

  // One random phase: a fresh table and small thresholds, then mostly complete press
  // sequences (press, hold for a random time, release) with some unknown codes,
  // broken releases and plain noise mixed in.
  task automatic test_random_presses(input int unsigned idle_pct, input int unsigned stall_pct);
    key_t keys[NKEYS];
    key_t k;
    int unsigned start;
    int unsigned pick;
    wait_results_done();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < NKEYS; i++) begin
      k = key_t'($urandom());
      if (i > 0 && $urandom_range(7) == 0) k = keys[$urandom_range(i - 1)];
      keys[i] = k;
    end
    set_codes({keys[2], keys[1], keys[0]}, {keys[5], keys[4], keys[3]});
    set_thresholds(cnt_t'($urandom_range(1, 6)), cnt_t'($urandom_range(1, 4)),
                   cnt_t'($urandom_range(1, 4)));
    start = scans_sent;
    while (scans_sent - start < PHASE_SCANS) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        k = (pick < 65) ? keys[$urandom_range(NKEYS - 1)] : key_t'($urandom());
        send_run(k, $urandom_range(1, long_thr + 3 * hold_thr));
        pick = $urandom_range(9);
        if (pick < 6) begin
          send_run(16'h0000, $urandom_range(1, rel_thr + 1));
        end else if (pick < 8) begin
          // A touch in the middle of the release restarts the count.
          send_run(16'h0000, $urandom_range(0, rel_thr));
          send_scan(key_t'($urandom()));
          send_run(16'h0000, rel_thr);
        end
      end else begin
        repeat ($urandom_range(1, 4)) send_scan(key_t'($urandom()));
      end
    end
  endtask

  // Receiver: ready changes on the falling edge only.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checker: every result beat is matched field by field against the oldest prediction.
  always @(posedge clk) begin
    press_result_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      results_seen++;
      if (pending_events.size() == 0) begin
        $error("result beat with no scan waiting for it");
        error_count++;
      end else begin
        want = pending_events.pop_front();
        short_seen += want.short_ev;
        long_seen += want.long_ev;
        repeat_seen += want.rep_ev;
        if (out_chan.short_press !== want.short_ev) begin
          $error("short_press: expected %0d, got %0d", want.short_ev, out_chan.short_press);
          error_count++;
        end
        if (out_chan.long_press !== want.long_ev) begin
          $error("long_press: expected %0d, got %0d", want.long_ev, out_chan.long_press);
          error_count++;
        end
        if (out_chan.repeat_press !== want.rep_ev) begin
          $error("repeat_press: expected %0d, got %0d", want.rep_ev, out_chan.repeat_press);
          error_count++;
        end
        if (out_chan.key_index !== want.key_idx) begin
          $error("key_index: expected %0d, got %0d", want.key_idx, out_chan.key_index);
          error_count++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Main sequence: reset once, then the tests in turn, then the final verdict.
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.key_code = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    scans_sent = 0;
    results_seen = 0;
    short_seen = 0;
    long_seen = 0;
    repeat_seen = 0;
    error_count = 0;
    tbl_left = '0;
    tbl_right = '0;
    long_thr = LONG_SCANS_RST;
    hold_thr = HOLD_INTV_RST;
    rel_thr = RELEASE_RST;
    ph = PH_IDLE;
    held = '0;
    press_cnt = '0;
    rel_cnt = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_press_kinds();
    test_thresholds_and_table();
    test_counter_limits();
    test_random_presses(0, 0);
    test_random_presses(61, 0);
    test_random_presses(0, 61);
    test_random_presses(20, 20);

    wait_results_done();
    repeat (8) @(posedge clk);
    $display("Run covered %0d scans and %0d results: %0d short, %0d long, %0d repeat events.",
             scans_sent, results_seen, short_seen, long_seen, repeat_seen);
    $display("Tests: reset defaults, all keys and press kinds, zero thresholds, long holds,",
             " and random presses under four handshake pressure settings.");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
